@@ hdl/obb_pkg.sv @@
`default_nettype none
package obb_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int SLOTS = 22;
  localparam int DEPTH = 2 * SLOTS;
  localparam int ADDR_W = 6;
  localparam int SLOT_W = 5;
  localparam int WORD_W = 32;
  localparam int OPW = 34;
  localparam int ACC_W = 2 * OPW;
  localparam int SQ_W = 63;

  localparam logic [SLOT_W-1:0] LAST_SLOT = 5'd21;
  localparam logic [SLOT_W-1:0] HI_BASE = 5'd3;
  localparam logic [SLOT_W-1:0] MAT_BASE = 5'd6;
  localparam logic [SLOT_W-1:0] ROW4_BASE = 5'd18;
  localparam logic [2:0] PT_BASE = 3'd2;
  localparam logic [2:0] PT_FAR = 3'd3;
  localparam logic [2:0] PT_CTR = 3'd5;
  localparam logic [1:0] W_COL = 2'd3;
  localparam logic [1:0] LAST_K = 2'd2;
  localparam logic [1:0] LAST_AX = 2'd2;
  localparam logic [2:0] PRJ_H1 = 3'd3;
  localparam logic [2:0] PRJ_DC = 3'd6;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_ACC_MAT,
    OP_MUL_PT,
    OP_ADD_SHR,
    OP_SAT,
    OP_DIV_PT,
    OP_HALF,
    OP_NORM,
    OP_MUL_SQ,
    OP_ADD,
    OP_SQRT_INIT,
    OP_SQRT_STEP,
    OP_DIV_AX,
    OP_CLR,
    OP_MUL_PRJ,
    OP_R_ADD,
    OP_D_CMP
  } op_e;

  typedef struct packed {
    op_e              op;
    logic             bx;
    logic [2:0]       pt;
    logic [1:0]       cc;
    logic [1:0]       kk;
    logic [1:0]       ai;
    logic [2:0]       hh;
    logic [SLOT_W-1:0] idx;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic norm_zero;
    logic norm_ok;
    logic sqrt_last;
    logic sep;
  } st_t;

  function automatic logic corner_hi(input logic [2:0] pt, input logic [1:0] k);
    logic r;
    unique case (pt)
      3'd0: r = (k == 2'd1);
      3'd1: r = (k == 2'd0);
      3'd3: r = 1'b1;
      3'd4: r = (k == 2'd2);
      default: r = 1'b0;
    endcase
    return r;
  endfunction

  function automatic logic [2:0] mid_pair(input logic [1:0] ai);
    logic [2:0] r;
    unique case (ai)
      2'd0: r = 3'd1;
      2'd1: r = 3'd0;
      default: r = 3'd4;
    endcase
    return r;
  endfunction

  function automatic logic signed [WORD_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
    logic signed [WORD_W-1:0] r;
    if ((&v[ACC_W-1:WORD_W-1]) || ~(|v[ACC_W-1:WORD_W-1])) begin
      r = v[WORD_W-1:0];
    end else if (v[ACC_W-1]) begin
      r = {1'b1, {(WORD_W-1){1'b0}}};
    end else begin
      r = {1'b0, {(WORD_W-1){1'b1}}};
    end
    return r;
  endfunction

endpackage
`default_nettype wire

@@ hdl/obb_ram.sv @@
`default_nettype none
module obb_ram #(
  parameter int WIDTH = obb_pkg::WORD_W,
  parameter int DEPTH = obb_pkg::DEPTH
) (
  input  wire logic                     clk_i,
  input  wire logic                     wr_en_i,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  wire logic [WIDTH-1:0]         wr_data_i,
  input  wire logic                     rd_en_i,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic      [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_o <= mem_q[rd_addr_i];
    end
  end

endmodule
`default_nettype wire

@@ hdl/obb_div.sv @@
`default_nettype none
module obb_div #(
  parameter int FRAC_BITS = obb_pkg::FRAC_BITS_DEF
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              start_i,
  input  wire logic signed [obb_pkg::OPW-1:0]    num_i,
  input  wire logic signed [obb_pkg::OPW-1:0]    den_i,
  output logic                                   done_o,
  output logic signed [obb_pkg::WORD_W-1:0]      quo_o
);

  localparam int DW = obb_pkg::OPW - 1;
  localparam int NW = DW + FRAC_BITS;
  localparam int CW = $clog2(NW + 1);
  localparam int WW = obb_pkg::WORD_W;
  localparam logic [NW-1:0] POS_LIM = NW'(64'h7fff_ffff);
  localparam logic [NW-1:0] NEG_LIM = NW'(64'h8000_0000);
  localparam logic [CW-1:0] LAST_CNT = CW'(NW - 1);

  logic            busy_q, done_q;
  logic [CW-1:0]   cnt_q;
  logic [NW-1:0]   nmag_q, quo_q;
  logic [DW-1:0]   dmag_q, rem_q;
  logic            neg_q, nneg_q, nzero_q, dzero_q;

  logic [obb_pkg::OPW-1:0] nabs, dabs;
  logic [DW:0]     r2, diff;
  logic            ge;

  assign nabs = num_i[obb_pkg::OPW-1] ? obb_pkg::OPW'(-num_i) : obb_pkg::OPW'(num_i);
  assign dabs = den_i[obb_pkg::OPW-1] ? obb_pkg::OPW'(-den_i) : obb_pkg::OPW'(den_i);
  assign r2   = {rem_q, nmag_q[NW-1]};
  assign ge   = r2 >= {1'b0, dmag_q};
  assign diff = r2 - {1'b0, dmag_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (busy_q) begin
        cnt_q <= cnt_q + CW'(1);
        if (cnt_q == LAST_CNT) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end else if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (busy_q) begin
      rem_q  <= ge ? diff[DW-1:0] : r2[DW-1:0];
      quo_q  <= {quo_q[NW-2:0], ge};
      nmag_q <= {nmag_q[NW-2:0], 1'b0};
    end else if (start_i) begin
      nmag_q  <= {nabs[DW-1:0], {FRAC_BITS{1'b0}}};
      dmag_q  <= dabs[DW-1:0];
      rem_q   <= '0;
      quo_q   <= '0;
      neg_q   <= num_i[obb_pkg::OPW-1] ^ den_i[obb_pkg::OPW-1];
      nneg_q  <= num_i[obb_pkg::OPW-1];
      nzero_q <= (num_i == '0);
      dzero_q <= (den_i == '0);
    end
  end

  always_comb begin
    if (dzero_q) begin
      if (nzero_q) begin
        quo_o = '0;
      end else if (nneg_q) begin
        quo_o = {1'b1, {(WW-1){1'b0}}};
      end else begin
        quo_o = {1'b0, {(WW-1){1'b1}}};
      end
    end else if (!neg_q) begin
      quo_o = (quo_q > POS_LIM) ? {1'b0, {(WW-1){1'b1}}} : quo_q[WW-1:0];
    end else begin
      quo_o = (quo_q > NEG_LIM) ? {1'b1, {(WW-1){1'b0}}} : -quo_q[WW-1:0];
    end
  end

  assign done_o = done_q;

endmodule
`default_nettype wire

@@ hdl/obb_dpath.sv @@
`default_nettype none
module obb_dpath #(
  parameter int FRAC_BITS = obb_pkg::FRAC_BITS_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire obb_pkg::cmd_t                 cmd_i,
  input  wire logic [obb_pkg::WORD_W-1:0]    rd_data_i,
  output obb_pkg::st_t                       st_o
);

  localparam int OPW = obb_pkg::OPW;
  localparam int ACC_W = obb_pkg::ACC_W;
  localparam int WW = obb_pkg::WORD_W;
  localparam int SQ_W = obb_pkg::SQ_W;
  localparam int AX_W = FRAC_BITS + 2;

  logic signed [WW-1:0]    prm_q [obb_pkg::SLOTS];
  logic signed [WW-1:0]    wacc_q [4];
  logic signed [WW-1:0]    wpt_q [6][3];
  logic signed [WW-1:0]    ctr_q [2][3];
  logic signed [OPW-1:0]   half_q [2][3][3];
  logic signed [AX_W-1:0]  axis_q [2][3][3];
  logic signed [OPW-1:0]   v_q [3];
  logic signed [ACC_W-1:0] acc_q, prod_q;
  logic [ACC_W-1:0]        racc_q;
  logic [SQ_W-1:0]         srem_q, sres_q, sbit_q;
  logic                    sep_q;

  logic                    dst_ax_q, dst_b_q;
  logic [2:0]              dst_i_q;
  logic [1:0]              dst_k_q;

  obb_pkg::op_e            op;
  logic signed [WW-1:0]    lo_s, hi_s, pcoord, m_op;
  logic signed [WW:0]      lc_sum;
  logic signed [OPW-1:0]   a_op, b_op, prj_vec;
  logic signed [ACC_W-1:0] mul_full;
  logic [ACC_W-1:0]        acc_abs;
  logic [OPW-1:0]          av [3];
  logic [OPW-1:0]          mx;
  logic                    ge30, lt29;
  logic [2:0]              jpt;
  logic [SQ_W-1:0]         s_try;
  logic                    div_start, div_done;
  logic signed [OPW-1:0]   div_num, div_den;
  logic signed [WW-1:0]    div_quo;

  assign op = cmd_i.op;

  assign lo_s   = prm_q[obb_pkg::SLOT_W'(cmd_i.kk)];
  assign hi_s   = prm_q[obb_pkg::HI_BASE + obb_pkg::SLOT_W'(cmd_i.kk)];
  assign lc_sum = (WW+1)'(lo_s) + (WW+1)'(hi_s);
  assign m_op   = prm_q[obb_pkg::MAT_BASE + obb_pkg::SLOT_W'({cmd_i.kk, cmd_i.cc})];
  assign jpt    = obb_pkg::mid_pair(cmd_i.ai);

  always_comb begin
    if (cmd_i.pt == obb_pkg::PT_CTR) begin
      pcoord = lc_sum[WW:1];
    end else if (obb_pkg::corner_hi(cmd_i.pt, cmd_i.kk)) begin
      pcoord = hi_s;
    end else begin
      pcoord = lo_s;
    end
  end

  always_comb begin
    if (cmd_i.hh < obb_pkg::PRJ_H1) begin
      prj_vec = half_q[0][cmd_i.hh[1:0]][cmd_i.kk];
    end else if (cmd_i.hh < obb_pkg::PRJ_DC) begin
      prj_vec = half_q[1][2'(cmd_i.hh - obb_pkg::PRJ_H1)][cmd_i.kk];
    end else begin
      prj_vec = OPW'(ctr_q[1][cmd_i.kk]) - OPW'(ctr_q[0][cmd_i.kk]);
    end
  end

  always_comb begin
    unique case (op)
      obb_pkg::OP_MUL_PT: begin
        a_op = OPW'(pcoord);
        b_op = OPW'(m_op);
      end
      obb_pkg::OP_MUL_SQ: begin
        a_op = v_q[cmd_i.kk];
        b_op = v_q[cmd_i.kk];
      end
      default: begin
        a_op = prj_vec;
        b_op = OPW'(axis_q[cmd_i.bx][cmd_i.ai][cmd_i.kk]);
      end
    endcase
  end

  assign mul_full = a_op * b_op;
  assign acc_abs  = acc_q[ACC_W-1] ? ACC_W'(-acc_q) : ACC_W'(acc_q);

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      av[k] = v_q[k][OPW-1] ? OPW'(-v_q[k]) : OPW'(v_q[k]);
    end
    mx = av[0];
    if (av[1] > mx) begin
      mx = av[1];
    end
    if (av[2] > mx) begin
      mx = av[2];
    end
  end

  assign ge30  = mx >= OPW'(64'h4000_0000);
  assign lt29  = mx < OPW'(64'h2000_0000);
  assign s_try = (sres_q + sbit_q);

  assign div_start = (op == obb_pkg::OP_DIV_PT) || (op == obb_pkg::OP_DIV_AX);
  assign div_num   = (op == obb_pkg::OP_DIV_PT) ? OPW'(wacc_q[cmd_i.cc]) : v_q[cmd_i.kk];
  assign div_den   = (op == obb_pkg::OP_DIV_PT) ? OPW'(wacc_q[obb_pkg::W_COL])
                                                : {1'b0, sres_q[OPW-2:0]};

  obb_div #(
    .FRAC_BITS(FRAC_BITS)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (div_num),
    .den_i  (div_den),
    .done_o (div_done),
    .quo_o  (div_quo)
  );

  always_ff @(posedge clk_i) begin
    if (div_start) begin
      dst_ax_q <= (op == obb_pkg::OP_DIV_AX);
      dst_b_q  <= cmd_i.bx;
      dst_i_q  <= (op == obb_pkg::OP_DIV_AX) ? {1'b0, cmd_i.ai} : cmd_i.pt;
      dst_k_q  <= (op == obb_pkg::OP_DIV_AX) ? cmd_i.kk : cmd_i.cc;
    end
    if (div_done) begin
      if (dst_ax_q) begin
        axis_q[dst_b_q][dst_i_q[1:0]][dst_k_q] <= div_quo[AX_W-1:0];
      end else begin
        wpt_q[dst_i_q][dst_k_q] <= div_quo;
      end
    end
    unique case (op)
      obb_pkg::OP_LOAD: begin
        prm_q[cmd_i.idx] <= rd_data_i;
      end
      obb_pkg::OP_ACC_MAT: begin
        acc_q <= ACC_W'(prm_q[obb_pkg::ROW4_BASE + obb_pkg::SLOT_W'(cmd_i.cc)]);
      end
      obb_pkg::OP_MUL_PT, obb_pkg::OP_MUL_SQ, obb_pkg::OP_MUL_PRJ: begin
        prod_q <= mul_full;
      end
      obb_pkg::OP_ADD_SHR: begin
        acc_q <= acc_q + (prod_q >>> FRAC_BITS);
      end
      obb_pkg::OP_ADD: begin
        acc_q <= acc_q + prod_q;
      end
      obb_pkg::OP_SAT: begin
        wacc_q[cmd_i.cc] <= obb_pkg::sat32(acc_q);
      end
      obb_pkg::OP_HALF: begin
        for (int k = 0; k < 3; k++) begin
          half_q[cmd_i.bx][cmd_i.ai][k] <=
            OPW'(((WW+1)'(wpt_q[jpt][k]) + (WW+1)'(wpt_q[obb_pkg::PT_FAR][k])) >>> 1)
            - OPW'(wpt_q[obb_pkg::PT_CTR][k]);
          v_q[k] <= OPW'(wpt_q[jpt][k]) - OPW'(wpt_q[obb_pkg::PT_BASE][k]);
          ctr_q[cmd_i.bx][k] <= wpt_q[obb_pkg::PT_CTR][k];
        end
        acc_q <= '0;
      end
      obb_pkg::OP_NORM: begin
        for (int k = 0; k < 3; k++) begin
          if (mx == '0) begin
            axis_q[cmd_i.bx][cmd_i.ai][k] <= '0;
          end else if (ge30) begin
            v_q[k] <= v_q[k] >>> 1;
          end else if (lt29) begin
            v_q[k] <= v_q[k] <<< 1;
          end
        end
      end
      obb_pkg::OP_SQRT_INIT: begin
        srem_q <= acc_q[SQ_W-1:0];
        sres_q <= '0;
        sbit_q <= {1'b1, {(SQ_W-1){1'b0}}};
      end
      obb_pkg::OP_SQRT_STEP: begin
        if (srem_q >= s_try) begin
          srem_q <= srem_q - s_try;
          sres_q <= (sres_q >> 1) + sbit_q;
        end else begin
          sres_q <= sres_q >> 1;
        end
        sbit_q <= sbit_q >> 2;
      end
      obb_pkg::OP_CLR: begin
        acc_q  <= '0;
        racc_q <= '0;
      end
      obb_pkg::OP_R_ADD: begin
        racc_q <= racc_q + acc_abs;
        acc_q  <= '0;
      end
      obb_pkg::OP_D_CMP: begin
        sep_q <= acc_abs > racc_q;
      end
      default: begin
      end
    endcase
  end

  assign st_o.div_done  = div_done;
  assign st_o.norm_zero = (mx == '0);
  assign st_o.norm_ok   = !ge30 && !lt29;
  assign st_o.sqrt_last = sbit_q[0];
  assign st_o.sep       = sep_q;

endmodule
`default_nettype wire

@@ hdl/obb_ctrl.sv @@
`default_nettype none
module obb_ctrl (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  input  wire logic                          in_last_i,
  output logic                               in_ready_o,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic                               out_overlap_o,
  output logic                               rd_en_o,
  output logic [obb_pkg::ADDR_W-1:0]         rd_addr_o,
  output obb_pkg::cmd_t                      cmd_o,
  input  wire obb_pkg::st_t                  st_i
);

  typedef enum logic [4:0] {
    S_IDLE, S_LD_RD, S_LD_WR,
    S_T_INIT, S_T_MUL, S_T_ADD, S_T_SAT, S_T_DIV, S_T_WAIT,
    S_A_HALF, S_A_NORM, S_A_SQMUL, S_A_SQADD, S_A_SQRT0, S_A_SQRT, S_A_DIV, S_A_WAIT,
    S_P_CLR, S_P_MUL, S_P_ADD, S_P_NEXT, S_P_CHK, S_DONE
  } state_e;

  state_e                     state_q;
  logic                       bx_q, res_q, out_valid_q, overlap_q;
  logic [obb_pkg::SLOT_W-1:0] idx_q;
  logic [2:0]                 pt_q, hh_q;
  logic [1:0]                 cc_q, kk_q, ai_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      bx_q        <= 1'b0;
      idx_q       <= '0;
      pt_q        <= '0;
      hh_q        <= '0;
      cc_q        <= '0;
      kk_q        <= '0;
      ai_q        <= '0;
      res_q       <= 1'b0;
      out_valid_q <= 1'b0;
      overlap_q   <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i && state_q != S_DONE) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i && in_last_i) begin
            bx_q    <= 1'b0;
            idx_q   <= '0;
            state_q <= S_LD_RD;
          end
        end
        S_LD_RD: state_q <= S_LD_WR;
        S_LD_WR: begin
          if (idx_q == obb_pkg::LAST_SLOT) begin
            pt_q    <= '0;
            cc_q    <= '0;
            state_q <= S_T_INIT;
          end else begin
            idx_q   <= idx_q + 5'd1;
            state_q <= S_LD_RD;
          end
        end
        S_T_INIT: begin
          kk_q    <= '0;
          state_q <= S_T_MUL;
        end
        S_T_MUL: state_q <= S_T_ADD;
        S_T_ADD: begin
          if (kk_q == obb_pkg::LAST_K) begin
            state_q <= S_T_SAT;
          end else begin
            kk_q    <= kk_q + 2'd1;
            state_q <= S_T_MUL;
          end
        end
        S_T_SAT: begin
          if (cc_q == obb_pkg::W_COL) begin
            cc_q    <= '0;
            state_q <= S_T_DIV;
          end else begin
            cc_q    <= cc_q + 2'd1;
            state_q <= S_T_INIT;
          end
        end
        S_T_DIV: state_q <= S_T_WAIT;
        S_T_WAIT: begin
          if (st_i.div_done) begin
            if (cc_q == obb_pkg::LAST_K) begin
              cc_q <= '0;
              if (pt_q == obb_pkg::PT_CTR) begin
                ai_q    <= '0;
                state_q <= S_A_HALF;
              end else begin
                pt_q    <= pt_q + 3'd1;
                state_q <= S_T_INIT;
              end
            end else begin
              cc_q    <= cc_q + 2'd1;
              state_q <= S_T_DIV;
            end
          end
        end
        S_A_HALF: state_q <= S_A_NORM;
        S_A_NORM: begin
          kk_q <= '0;
          if (st_i.norm_zero) begin
            if (ai_q != obb_pkg::LAST_AX) begin
              ai_q    <= ai_q + 2'd1;
              state_q <= S_A_HALF;
            end else if (!bx_q) begin
              bx_q    <= 1'b1;
              idx_q   <= '0;
              state_q <= S_LD_RD;
            end else begin
              bx_q    <= 1'b0;
              ai_q    <= '0;
              state_q <= S_P_CLR;
            end
          end else if (st_i.norm_ok) begin
            state_q <= S_A_SQMUL;
          end
        end
        S_A_SQMUL: state_q <= S_A_SQADD;
        S_A_SQADD: begin
          if (kk_q == obb_pkg::LAST_K) begin
            state_q <= S_A_SQRT0;
          end else begin
            kk_q    <= kk_q + 2'd1;
            state_q <= S_A_SQMUL;
          end
        end
        S_A_SQRT0: state_q <= S_A_SQRT;
        S_A_SQRT: begin
          if (st_i.sqrt_last) begin
            kk_q    <= '0;
            state_q <= S_A_DIV;
          end
        end
        S_A_DIV: state_q <= S_A_WAIT;
        S_A_WAIT: begin
          if (st_i.div_done) begin
            if (kk_q != obb_pkg::LAST_K) begin
              kk_q    <= kk_q + 2'd1;
              state_q <= S_A_DIV;
            end else if (ai_q != obb_pkg::LAST_AX) begin
              ai_q    <= ai_q + 2'd1;
              state_q <= S_A_HALF;
            end else if (!bx_q) begin
              bx_q    <= 1'b1;
              idx_q   <= '0;
              state_q <= S_LD_RD;
            end else begin
              bx_q    <= 1'b0;
              ai_q    <= '0;
              state_q <= S_P_CLR;
            end
          end
        end
        S_P_CLR: begin
          hh_q    <= '0;
          kk_q    <= '0;
          state_q <= S_P_MUL;
        end
        S_P_MUL: state_q <= S_P_ADD;
        S_P_ADD: begin
          if (kk_q == obb_pkg::LAST_K) begin
            state_q <= S_P_NEXT;
          end else begin
            kk_q    <= kk_q + 2'd1;
            state_q <= S_P_MUL;
          end
        end
        S_P_NEXT: begin
          if (hh_q == obb_pkg::PRJ_DC) begin
            state_q <= S_P_CHK;
          end else begin
            hh_q    <= hh_q + 3'd1;
            kk_q    <= '0;
            state_q <= S_P_MUL;
          end
        end
        S_P_CHK: begin
          if (st_i.sep) begin
            res_q   <= 1'b0;
            state_q <= S_DONE;
          end else if (bx_q && ai_q == obb_pkg::LAST_AX) begin
            res_q   <= 1'b1;
            state_q <= S_DONE;
          end else begin
            if (ai_q == obb_pkg::LAST_AX) begin
              ai_q <= '0;
              bx_q <= 1'b1;
            end else begin
              ai_q <= ai_q + 2'd1;
            end
            state_q <= S_P_CLR;
          end
        end
        S_DONE: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q <= 1'b1;
            overlap_q   <= res_q;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    cmd_o     = '0;
    cmd_o.op  = obb_pkg::OP_NONE;
    cmd_o.bx  = bx_q;
    cmd_o.pt  = pt_q;
    cmd_o.cc  = cc_q;
    cmd_o.kk  = kk_q;
    cmd_o.ai  = ai_q;
    cmd_o.hh  = hh_q;
    cmd_o.idx = idx_q;
    unique case (state_q)
      S_LD_WR:   cmd_o.op = obb_pkg::OP_LOAD;
      S_T_INIT:  cmd_o.op = obb_pkg::OP_ACC_MAT;
      S_T_MUL:   cmd_o.op = obb_pkg::OP_MUL_PT;
      S_T_ADD:   cmd_o.op = obb_pkg::OP_ADD_SHR;
      S_T_SAT:   cmd_o.op = obb_pkg::OP_SAT;
      S_T_DIV:   cmd_o.op = obb_pkg::OP_DIV_PT;
      S_A_HALF:  cmd_o.op = obb_pkg::OP_HALF;
      S_A_NORM:  cmd_o.op = obb_pkg::OP_NORM;
      S_A_SQMUL: cmd_o.op = obb_pkg::OP_MUL_SQ;
      S_A_SQADD: cmd_o.op = obb_pkg::OP_ADD;
      S_A_SQRT0: cmd_o.op = obb_pkg::OP_SQRT_INIT;
      S_A_SQRT:  cmd_o.op = obb_pkg::OP_SQRT_STEP;
      S_A_DIV:   cmd_o.op = obb_pkg::OP_DIV_AX;
      S_P_CLR:   cmd_o.op = obb_pkg::OP_CLR;
      S_P_MUL:   cmd_o.op = obb_pkg::OP_MUL_PRJ;
      S_P_ADD:   cmd_o.op = obb_pkg::OP_ADD;
      S_P_NEXT:  cmd_o.op = (hh_q == obb_pkg::PRJ_DC) ? obb_pkg::OP_D_CMP : obb_pkg::OP_R_ADD;
      default:   cmd_o.op = obb_pkg::OP_NONE;
    endcase
  end

  assign in_ready_o    = (state_q == S_IDLE);
  assign out_valid_o   = out_valid_q;
  assign out_overlap_o = overlap_q;
  assign rd_en_o       = (state_q == S_LD_RD);
  assign rd_addr_o     = obb_pkg::ADDR_W'(idx_q)
                       + (bx_q ? obb_pkg::ADDR_W'(obb_pkg::SLOTS) : obb_pkg::ADDR_W'(0));

endmodule
`default_nettype wire

@@ hdl/obb_face_axis_overlap_test.sv @@
// channel   dir  tdata                                   tuser    tlast
// s_axis    in   slot [4:0], coord_value [36:5], pad     box_sel  last_word
// m_axis    out  overlap [0], pad                        -        -
//
// a word without tlast is stored and the next is taken at once
// a word with tlast starts the test: per box the slots are loaded, then six point
// transforms and three axis builds follow, each divide running in the shared
// divider; the face-axis projections then decide the overlap
// the result waits in an output register; a new run may start meanwhile
// reset clears control only; the box store holds no reset value
`default_nettype none
module obb_face_axis_overlap_test #(
  parameter int FRAC_BITS = obb_pkg::FRAC_BITS_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [39:0] s_axis_tdata_i,   // slot, coord_value, zero pad
  input  wire logic        s_axis_tuser_i,   // box_sel
  input  wire logic        s_axis_tlast_i,
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [7:0]       m_axis_tdata_o    // overlap, zero pad
);

  logic                          accept, wr_en, rd_en, overlap;
  logic [obb_pkg::SLOT_W-1:0]    slot;
  logic [obb_pkg::ADDR_W-1:0]    wr_addr, rd_addr;
  logic [obb_pkg::WORD_W-1:0]    rd_data;
  obb_pkg::cmd_t                 cmd;
  obb_pkg::st_t                  st;

  assign accept  = s_axis_tvalid_i && s_axis_tready_o;
  assign slot    = s_axis_tdata_i[4:0];
  assign wr_en   = accept && (slot <= obb_pkg::LAST_SLOT);
  assign wr_addr = obb_pkg::ADDR_W'(slot)
                 + (s_axis_tuser_i ? obb_pkg::ADDR_W'(obb_pkg::SLOTS) : obb_pkg::ADDR_W'(0));

  obb_ram #(
    .WIDTH(obb_pkg::WORD_W),
    .DEPTH(obb_pkg::DEPTH)
  ) u_store (
    .clk_i    (clk_i),
    .wr_en_i  (wr_en),
    .wr_addr_i(wr_addr),
    .wr_data_i(s_axis_tdata_i[36:5]),
    .rd_en_i  (rd_en),
    .rd_addr_i(rd_addr),
    .rd_data_o(rd_data)
  );

  obb_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid_i),
    .in_last_i    (s_axis_tlast_i),
    .in_ready_o   (s_axis_tready_o),
    .out_valid_o  (m_axis_tvalid_o),
    .out_ready_i  (m_axis_tready_i),
    .out_overlap_o(overlap),
    .rd_en_o      (rd_en),
    .rd_addr_o    (rd_addr),
    .cmd_o        (cmd),
    .st_i         (st)
  );

  obb_dpath #(
    .FRAC_BITS(FRAC_BITS)
  ) u_dpath (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd),
    .rd_data_i(rd_data),
    .st_o     (st)
  );

  assign m_axis_tdata_o = {7'd0, overlap};

  a_load_stays_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && !s_axis_tlast_i |=> s_axis_tready_o)
    else $error("ready dropped after a plain load item");

  a_last_starts_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && s_axis_tlast_i |=> !s_axis_tready_o)
    else $error("test did not start on last item");

  a_result_from_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> $past(!s_axis_tready_o))
    else $error("result raised without a running test");

  a_no_store_read_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_en |-> !s_axis_tready_o)
    else $error("store read while idle");

endmodule
`default_nettype wire

@@ verif/tb_top.sv @@
`timescale 1ns / 100ps
`default_nettype none
module tb_top;

  localparam int FRAC = obb_pkg::FRAC_BITS_DEF;
  localparam longint CYCLE_LIMIT = 30000000;
  localparam int QUIET_FROM = 30000;
  localparam int QUIET_TO = 70000;

  typedef struct {
    logic                       sel;
    logic [obb_pkg::SLOT_W-1:0] slot;
    logic [31:0]                value;
    logic                       last;
    logic                       hold;
  } word_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata = '0;
  logic        s_tuser = 1'b0;
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;

  word_t  word_q[$];
  logic   overlap_q[$];
  logic [31:0] box_mem[obb_pkg::DEPTH];
  longint cyc = 0;
  int     n_err = 0;
  int     n_words = 0;

  obb_face_axis_overlap_test i_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),   // slot [4:0], coord_value [36:5], pad
    .s_axis_tuser_i  (s_tuser),   // box_sel
    .s_axis_tlast_i  (s_tlast),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata)    // overlap [0], pad
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic bit go_idle();
    if (cyc > QUIET_FROM && cyc < QUIET_TO) return 1'b0;
    return $urandom_range(0, 99) < 12;
  endfunction

  function automatic longint sat_w(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint abs_l(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic longint floor_sqrt(longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return longint'(res);
  endfunction

  function automatic void map_point(input longint m[16], input longint p[3],
                                    output longint o[3]);
    longint acc[4];
    longint s;
    for (int c = 0; c < 4; c++) begin
      s = m[12 + c];
      for (int k = 0; k < 3; k++) s += (p[k] * m[4 * k + c]) >>> FRAC;
      acc[c] = sat_w(s);
    end
    for (int c = 0; c < 3; c++) begin
      if (acc[3] == 0)
        o[c] = acc[c] > 0 ? 64'sd2147483647 : (acc[c] < 0 ? -64'sd2147483648 : 0);
      else
        o[c] = sat_w((acc[c] * (64'sd1 <<< FRAC)) / acc[3]);
    end
  endfunction

  function automatic void face_axis(input longint e[3], output longint ax[3]);
    longint v[3];
    longint mx, sum, len;
    mx = 0;
    for (int k = 0; k < 3; k++) begin
      v[k] = e[k];
      if (abs_l(v[k]) > mx) mx = abs_l(v[k]);
    end
    if (mx == 0) begin
      ax = '{0, 0, 0};
      return;
    end
    while (mx >= (64'sd1 <<< 30)) begin
      mx = 0;
      for (int k = 0; k < 3; k++) begin
        v[k] = v[k] >>> 1;
        if (abs_l(v[k]) > mx) mx = abs_l(v[k]);
      end
    end
    while (mx < (64'sd1 <<< 29)) begin
      for (int k = 0; k < 3; k++) v[k] *= 2;
      mx *= 2;
    end
    sum = 0;
    for (int k = 0; k < 3; k++) sum += v[k] * v[k];
    len = floor_sqrt(sum);
    for (int k = 0; k < 3; k++) ax[k] = (v[k] * (64'sd1 <<< FRAC)) / len;
  endfunction

  function automatic longint rd(int idx);
    return longint'($signed(box_mem[idx]));
  endfunction

  function automatic void world_box(input int b, output longint ctr[3],
                                    output longint half[3][3], output longint axis[3][3]);
    longint lo[3], hi[3], lc[3], m[16], cn[5][3], wp[5][3], ed[3], pt[3], o[3];
    int base, j;
    base = b * obb_pkg::SLOTS;
    for (int k = 0; k < 3; k++) begin
      lo[k] = rd(base + k);
      hi[k] = rd(base + 3 + k);
      lc[k] = (lo[k] + hi[k]) >>> 1;
    end
    for (int k = 0; k < 16; k++) m[k] = rd(base + 6 + k);
    cn[0] = '{lo[0], hi[1], lo[2]};
    cn[1] = '{hi[0], lo[1], lo[2]};
    cn[2] = '{lo[0], lo[1], lo[2]};
    cn[3] = '{hi[0], hi[1], hi[2]};
    cn[4] = '{lo[0], lo[1], hi[2]};
    for (int i = 0; i < 5; i++) begin
      pt = cn[i];
      map_point(m, pt, o);
      wp[i] = o;
    end
    map_point(m, lc, ctr);
    for (int i = 0; i < 3; i++) begin
      j = (i == 0) ? 1 : (i == 1) ? 0 : 4;
      for (int k = 0; k < 3; k++) begin
        half[i][k] = ((wp[j][k] + wp[3][k]) >>> 1) - ctr[k];
        ed[k] = wp[j][k] - wp[2][k];
      end
      face_axis(ed, o);
      axis[i] = o;
    end
  endfunction

  function automatic logic boxes_overlap();
    longint ctr[2][3], half[2][3][3], axis[2][3][3], dc[3];
    longint c3[3], h3[3][3], a3[3][3];
    longint r0, r1, d;
    for (int b = 0; b < 2; b++) begin
      world_box(b, c3, h3, a3);
      ctr[b] = c3;
      half[b] = h3;
      axis[b] = a3;
    end
    for (int k = 0; k < 3; k++) dc[k] = ctr[1][k] - ctr[0][k];
    for (int b = 0; b < 2; b++) begin
      for (int j = 0; j < 3; j++) begin
        r0 = 0;
        r1 = 0;
        d = 0;
        for (int k = 0; k < 3; k++) begin
          r0 += abs_l(half[0][k][0] * axis[b][j][0] + half[0][k][1] * axis[b][j][1]
                      + half[0][k][2] * axis[b][j][2]);
          r1 += abs_l(half[1][k][0] * axis[b][j][0] + half[1][k][1] * axis[b][j][1]
                      + half[1][k][2] * axis[b][j][2]);
          d += dc[k] * axis[b][j][k];
        end
        if (abs_l(d) > r0 + r1) return 1'b0;
      end
    end
    return 1'b1;
  endfunction

  function automatic void take_word(word_t w);
    if (w.slot < obb_pkg::SLOTS) box_mem[w.sel * obb_pkg::SLOTS + w.slot] = w.value;
    if (w.last) overlap_q.push_back(boxes_overlap());
  endfunction

  // driver
  always @(posedge clk) begin
    word_t nw;
    if (rst_n) begin
      if (!s_tvalid || s_tready) begin
        if (s_tvalid) begin
          take_word(word_t'{s_tuser, s_tdata[4:0], s_tdata[36:5], s_tlast, 1'b0});
          n_words++;
        end
        if (word_q.size() > 0 && !go_idle() &&
            !(word_q[0].hold && overlap_q.size() > 0)) begin
          nw = word_q.pop_front();
          s_tvalid <= 1'b1;
          s_tdata <= {3'b000, nw.value, nw.slot};
          s_tuser <= nw.sel;
          s_tlast <= nw.last;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  task automatic report_mismatch(input string what);
    $display("mismatch at cycle %0d: %s", cyc, what);
    n_err++;
  endtask

  // monitor
  always @(posedge clk) begin
    if (rst_n) begin
      if (m_tvalid && m_tready) begin
        if (overlap_q.size() == 0) begin
          report_mismatch("unexpected result");
        end else if (m_tdata[0] !== overlap_q[0]) begin
          report_mismatch($sformatf("overlap %0b, expected %0b", m_tdata[0],
                                    overlap_q.pop_front()));
        end else begin
          void'(overlap_q.pop_front());
        end
      end
      m_tready <= !go_idle();
    end
  end

  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  function automatic logic [31:0] q16(int lo_i, int hi_i);
    return 32'($signed($urandom_range(0, (hi_i - lo_i) << 16)) + (lo_i <<< 16));
  endfunction

  function automatic void push(logic sel, int slot, logic [31:0] v, logic last,
                               logic hold = 1'b0);
    word_q.push_back(word_t'{sel, obb_pkg::SLOT_W'(slot), v, last, hold});
  endfunction

  // one box in shuffled slot order, plausible geometry unless wild
  function automatic void load_box(logic b, bit wild, bit last);
    logic [31:0] v[22];
    int ord[22];
    int j, t;
    for (int k = 0; k < 3; k++) begin
      v[k] = q16(-8, 8);
      v[3 + k] = v[k] + q16(0, 4);
    end
    for (int r = 0; r < 4; r++)
      for (int c = 0; c < 4; c++) begin
        if (r < 3 && c < 3) v[6 + 4 * r + c] = 32'($signed($urandom_range(0, 3 << 16)) - (3 << 15));
        else if (r < 3) v[6 + 4 * r + c] = ($urandom_range(0, 9) == 0) ? q16(-1, 1) : 0;
        else if (c < 3) v[6 + 4 * r + c] = q16(-6, 6);
        else v[6 + 4 * r + c] = ($urandom_range(0, 5) == 0) ? q16(0, 2) : 32'h10000;
      end
    if (wild) for (int k = 0; k < 22; k++) if ($urandom_range(0, 2) == 0) v[k] = $urandom;
    for (int k = 0; k < 22; k++) ord[k] = k;
    for (int k = 21; k > 0; k--) begin
      j = $urandom_range(0, k);
      t = ord[k];
      ord[k] = ord[j];
      ord[j] = t;
    end
    for (int k = 0; k < 22; k++) push(b, ord[k], v[ord[k]], last && k == 21);
  endfunction

  function automatic void unit_box(logic b, int off);
    for (int k = 0; k < 3; k++) begin
      push(b, k, 32'(off <<< 16), 1'b0);
      push(b, 3 + k, 32'((off + 1) <<< 16), 1'b0);
    end
    for (int k = 0; k < 16; k++) push(b, 6 + k, (k % 5 == 0) ? 32'h10000 : 0, 1'b0);
  endfunction

  function automatic void t_rand_step();
    int mode;
    mode = $urandom_range(0, 9);
    if (mode < 4) begin
      load_box($urandom_range(0, 1), $urandom_range(0, 7) == 0, 1'b1);
    end else if (mode < 7) begin
      load_box(1'b0, $urandom_range(0, 7) == 0, 1'b0);
      load_box(1'b1, $urandom_range(0, 7) == 0, 1'b1);
    end else begin
      repeat ($urandom_range(0, 4))
        push($urandom_range(0, 1), $urandom_range(0, 31), $urandom, 1'b0);
      push($urandom_range(0, 1), $urandom_range(0, 31),
           $urandom_range(0, 1) ? $urandom : q16(-4, 4), 1'b1, $urandom_range(0, 9) == 0);
    end
  endfunction

  initial begin
    int n;
    for (int k = 0; k < obb_pkg::DEPTH; k++) box_mem[k] = '0;
    // directed: touching unit cubes, then apart, zero w, zero edge, extremes
    unit_box(1'b0, 0);
    unit_box(1'b1, 1);
    push(1'b1, 0, 32'h0001_0000, 1'b1);
    push(1'b1, 0, 32'h0001_0001, 1'b1);
    push(1'b1, 18, 32'h0005_0000, 1'b1, 1'b1);
    push(1'b0, 9, 0, 1'b0);
    push(1'b0, 21, 0, 1'b1);
    push(1'b1, 3, 32'h0001_0000, 1'b0);
    push(1'b1, 4, 32'h0001_0000, 1'b0);
    push(1'b1, 5, 32'h0001_0000, 1'b1);
    push(1'b0, 21, 32'h7fff_ffff, 1'b1);
    push(1'b1, 12, 32'h8000_0000, 1'b0);
    push(1'b0, 2, 32'hffff_ffff, 1'b0);
    push(1'b1, 31, 32'h1234_5678, 1'b1);
    push(1'b0, 22, 32'h0, 1'b1);
    n = word_q.size();
    while (n < 1300) begin
      t_rand_step();
      n = word_q.size() + n_words;
    end
    wait (word_q.size() == 0 && !s_tvalid);
    wait (overlap_q.size() == 0);
    repeat (5000) @(posedge clk);
    if (n_err == 0 && overlap_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
  end

endmodule
`default_nettype wire

@@ filelist.f @@
hdl/obb_pkg.sv
hdl/obb_ram.sv
hdl/obb_div.sv
hdl/obb_dpath.sv
hdl/obb_ctrl.sv
hdl/obb_face_axis_overlap_test.sv
verif/tb_top.sv
